// ----- hw/rtl/rcad_pkg.sv -----
// ----------------------------------------------------------------------------
// rcad_pkg
// Shared types and constants of the cutout address decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package rcad_pkg;

   // action codes of an input transaction
   localparam logic [1:0] ACT_START  = 2'd0;
   localparam logic [1:0] ACT_SAMPLE = 2'd1;
   localparam logic [1:0] ACT_DECODE = 2'd2;
   localparam logic [1:0] ACT_CLEAR  = 2'd3;

   localparam int DEF_SAMPLE_DEPTH = 64;
   localparam int MIN_SAMPLES      = 40;
   localparam int MIN_WINDOW       = 20;
   localparam int SEARCH_SPAN      = 20;
   localparam int HIGH_OFFSET      = 128;
   localparam int BIT_COUNT        = 8;
   localparam int AGREE_DEPTH      = 4;
   localparam int LOW_BIT          = 2;
   localparam int HIGH_BIT         = 3;

   typedef struct packed {
      logic [1:0]  action;
      logic [11:0] sample;
   } req_type;

   typedef struct packed {
      logic [14:0] last_address;
      logic        address_updated;
      logic [7:0]  channel_one;
      logic [7:0]  channel_two;
   } rsp_type;

   // decoder status toward the top level
   typedef struct packed {
      logic       done;
      logic [7:0] ch1;
      logic [7:0] ch2;
   } dec_stat_type;

   typedef enum logic [2:0] {
      DEC_IDLE,
      DEC_SETUP,
      DEC_WSTART,
      DEC_MINMAX,
      DEC_THR,
      DEC_SEARCH,
      DEC_BITS,
      DEC_DONE
   } dec_state_type;

endpackage

`default_nettype wire

// ----- hw/rtl/rcad_sample_store.sv -----
// ----------------------------------------------------------------------------
// rcad_sample_store
// Sample memory: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module rcad_sample_store #(
   parameter int SAMPLE_DEPTH = 64,
   parameter int AW = $clog2(SAMPLE_DEPTH)
) (
   input  wire logic          clock,
   input  wire logic          wr_en,
   input  wire logic [AW-1:0] wr_addr,
   input  wire logic [11:0]   wr_data,
   input  wire logic [AW-1:0] rd_addr,
   output logic [11:0]        rd_data
);

   logic [11:0] mem [SAMPLE_DEPTH];
   logic [11:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // read port, registered read data
   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ----- hw/rtl/rcad_window_decoder.sv -----
// ----------------------------------------------------------------------------
// rcad_window_decoder
// Walks the sample store over two windows: min/max, threshold, falling
// crossing search and bit sampling, giving the two channel bytes.
// ----------------------------------------------------------------------------
`default_nettype none

module rcad_window_decoder
   import rcad_pkg::*;
#(
   parameter int SAMPLE_DEPTH = 64,
   parameter int AW = $clog2(SAMPLE_DEPTH),
   parameter int CW = $clog2(SAMPLE_DEPTH + 1)
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          start,
   input  wire logic [CW-1:0] count,
   input  wire logic          ack,
   output logic [AW-1:0]      rd_addr,
   input  wire logic [11:0]   rd_data,
   output dec_stat_type       stat
);

   // n/3 by reciprocal multiplication
   localparam int S  = CW + 2;
   localparam int PW = CW + S;
   localparam logic [S-1:0] RECIP3 = S'(((2 ** S) + 2) / 3);

   dec_state_type state_ff, state_in;
   logic          win_ff, win_in;
   logic [CW-1:0] base_ff, base_in, len_ff, len_in, cnt_ff, cnt_in, doff_ff, doff_in;
   logic [PW-1:0] prod_ff, prod_in;
   logic          dvld_ff, dvld_in;
   logic [11:0]   lo_ff, lo_in, hi_ff, hi_in, thr_ff, thr_in, prev_ff, prev_in;
   logic [4:0]    sb_ff, sb_in;
   logic [7:0]    val_ff, val_in, ch1_ff, ch1_in, ch2_ff, ch2_in;

   logic          issue;
   logic [CW-1:0] issue_off, bit_off, limit;
   logic          wend;
   logic [7:0]    wres;
   logic [12:0]   mid_sum;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= DEC_IDLE;
         dvld_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         dvld_ff  <= dvld_in;
      end
   end

   always_ff @(posedge clock) begin
      win_ff  <= win_in;
      base_ff <= base_in;
      len_ff  <= len_in;
      cnt_ff  <= cnt_in;
      doff_ff <= doff_in;
      prod_ff <= prod_in;
      lo_ff   <= lo_in;
      hi_ff   <= hi_in;
      thr_ff  <= thr_in;
      prev_ff <= prev_in;
      sb_ff   <= sb_in;
      val_ff  <= val_in;
      ch1_ff  <= ch1_in;
      ch2_ff  <= ch2_in;
   end

   assign bit_off = CW'(sb_ff) + (cnt_ff << 1) + CW'(3);
   assign limit   = (len_ff == CW'(MIN_WINDOW)) ? CW'(SEARCH_SPAN - 1) : CW'(SEARCH_SPAN);
   assign mid_sum = {1'b0, lo_ff} + {1'b0, hi_ff};
   assign rd_addr = AW'(base_ff + issue_off);

   // sequencer
   always_comb begin
      state_in  = state_ff;
      win_in    = win_ff;
      base_in   = base_ff;
      len_in    = len_ff;
      cnt_in    = cnt_ff;
      prod_in   = prod_ff;
      lo_in     = lo_ff;
      hi_in     = hi_ff;
      thr_in    = thr_ff;
      prev_in   = prev_ff;
      sb_in     = sb_ff;
      val_in    = val_ff;
      ch1_in    = ch1_ff;
      ch2_in    = ch2_ff;
      issue     = 1'b0;
      issue_off = cnt_ff;
      wend      = 1'b0;
      wres      = 8'd0;

      case (state_ff)
         DEC_IDLE: begin
            if (start) begin
               base_in  = count >> 3;
               prod_in  = PW'(count) * PW'(RECIP3);
               state_in = DEC_SETUP;
            end
         end
         DEC_SETUP: begin
            len_in   = prod_ff[S +: CW];
            win_in   = 1'b0;
            state_in = DEC_WSTART;
         end
         DEC_WSTART: begin
            if (len_ff < CW'(MIN_WINDOW)) begin
               wend = 1'b1;
            end else begin
               lo_in    = 12'hFFF;
               hi_in    = 12'd0;
               cnt_in   = '0;
               state_in = DEC_MINMAX;
            end
         end
         DEC_MINMAX: begin
            if (dvld_ff) begin
               if (rd_data < lo_ff) lo_in = rd_data;
               if (rd_data > hi_ff) hi_in = rd_data;
            end
            if (cnt_ff < len_ff) begin
               issue  = 1'b1;
               cnt_in = cnt_ff + CW'(1);
            end else if (!dvld_ff) begin
               state_in = DEC_THR;
            end
         end
         DEC_THR: begin
            thr_in   = mid_sum[12:1];
            cnt_in   = '0;
            state_in = DEC_SEARCH;
         end
         DEC_SEARCH: begin
            if (dvld_ff) prev_in = rd_data;
            if (dvld_ff && doff_ff != '0 && prev_ff > thr_ff && rd_data < thr_ff) begin
               sb_in    = doff_ff[4:0];
               val_in   = 8'd0;
               cnt_in   = '0;
               state_in = DEC_BITS;
            end else if (cnt_ff < limit) begin
               issue  = 1'b1;
               cnt_in = cnt_ff + CW'(1);
            end else if (!dvld_ff) begin
               wend = 1'b1;
            end
         end
         DEC_BITS: begin
            issue_off = bit_off;
            if (dvld_ff && rd_data < thr_ff) begin
               val_in[doff_ff[2:0]] = 1'b1;
            end
            if (cnt_ff < CW'(BIT_COUNT) && bit_off < len_ff) begin
               issue  = 1'b1;
               cnt_in = cnt_ff + CW'(1);
            end else if (!dvld_ff) begin
               wend = 1'b1;
               wres = val_ff;
            end
         end
         DEC_DONE: begin
            if (ack) state_in = DEC_IDLE;
         end
         default: begin
            state_in = DEC_IDLE;
         end
      endcase

      // window finished: store byte, then next window or done
      if (wend) begin
         if (!win_ff) begin
            ch1_in   = wres;
            win_in   = 1'b1;
            base_in  = base_ff + len_ff;
            state_in = DEC_WSTART;
         end else begin
            ch2_in   = wres;
            state_in = DEC_DONE;
         end
      end
   end

   // track the offset of the read in flight
   assign dvld_in = issue;
   assign doff_in = (state_ff == DEC_BITS) ? cnt_ff : issue_off;

   assign stat.done = (state_ff == DEC_DONE);
   assign stat.ch1  = ch1_ff;
   assign stat.ch2  = ch2_ff;

endmodule

`default_nettype wire

// ----- hw/rtl/railcom_cutout_address_decoder.sv -----
// ----------------------------------------------------------------------------
// railcom_cutout_address_decoder
// Captures cutout samples, decodes the two channels and filters addresses.
// ----------------------------------------------------------------------------
// Usage:
//   req channel (valid/ready) carries one action and a 12-bit sample.
//   For start, sample and clear transactions a result appears in the rsp
//   register the cycle after acceptance, and a new request is taken while
//   the previous result is being taken.
//   A decode transaction with 40 or more stored samples runs the window
//   decoder over the sample memory: per window a min/max pass, the crossing
//   search and the bit sampling.
//   During a decode req_ready stays low.
//   Every transaction gives exactly one result. When rsp_ready is low the
//   result waits in the output register and no new request is taken
//   until it leaves.
//   Reset clears capture state, part latches, history and the published
//   address; sample memory contents are not cleared.
// ----------------------------------------------------------------------------
`default_nettype none

module railcom_cutout_address_decoder
   import rcad_pkg::*;
#(
   parameter int SAMPLE_DEPTH = DEF_SAMPLE_DEPTH
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_ready,
   input  wire req_type req_data,
   output logic         rsp_valid,
   input  wire logic    rsp_ready,
   output rsp_type      rsp_data
);

   localparam int AW = $clog2(SAMPLE_DEPTH);
   localparam int CW = $clog2(SAMPLE_DEPTH + 1);

   logic          capt_ff, capt_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic          busy_ff, busy_in;
   logic [13:0]   lowp_ff, lowp_in, highp_ff, highp_in;
   logic          lowv_ff, lowv_in, highv_ff, highv_in;
   logic [15:0]   hist_ff [AGREE_DEPTH];
   logic [15:0]   hist_in [AGREE_DEPTH];
   logic [1:0]    hptr_ff, hptr_in;
   logic [15:0]   acc_ff, acc_in;
   logic          rvld_ff, rvld_in;
   rsp_type       rdat_ff, rdat_in;

   logic          accept, out_free, wr_en, dec_start, dec_ack;
   logic [AW-1:0] rd_addr;
   logic [11:0]   rd_data;
   dec_stat_type  dstat;
   logic [13:0]   part;
   logic [15:0]   addr;
   logic          all_eq, updated;

   assign out_free  = !rvld_ff || rsp_ready;
   assign req_ready = !busy_ff && out_free;
   assign accept    = req_valid && req_ready;
   assign wr_en     = accept && req_data.action == ACT_SAMPLE && capt_ff
                      && cnt_ff < CW'(SAMPLE_DEPTH);
   assign dec_start = accept && req_data.action == ACT_DECODE
                      && cnt_ff >= CW'(MIN_SAMPLES);
   assign dec_ack   = dstat.done && out_free;

   rcad_sample_store #(.SAMPLE_DEPTH(SAMPLE_DEPTH), .AW(AW)) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (AW'(cnt_ff)),
      .wr_data (req_data.sample),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   rcad_window_decoder #(.SAMPLE_DEPTH(SAMPLE_DEPTH), .AW(AW), .CW(CW)) u_dec (
      .clock   (clock),
      .reset   (reset),
      .start   (dec_start),
      .count   (cnt_ff),
      .ack     (dec_ack),
      .rd_addr (rd_addr),
      .rd_data (rd_data),
      .stat    (dstat)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         capt_ff  <= 1'b0;
         cnt_ff   <= '0;
         busy_ff  <= 1'b0;
         lowp_ff  <= '0;
         lowv_ff  <= 1'b0;
         highp_ff <= '0;
         highv_ff <= 1'b0;
         for (int i = 0; i < AGREE_DEPTH; i++) hist_ff[i] <= '0;
         hptr_ff  <= '0;
         acc_ff   <= '0;
         rvld_ff  <= 1'b0;
      end else begin
         capt_ff  <= capt_in;
         cnt_ff   <= cnt_in;
         busy_ff  <= busy_in;
         lowp_ff  <= lowp_in;
         lowv_ff  <= lowv_in;
         highp_ff <= highp_in;
         highv_ff <= highv_in;
         for (int i = 0; i < AGREE_DEPTH; i++) hist_ff[i] <= hist_in[i];
         hptr_ff  <= hptr_in;
         acc_ff   <= acc_in;
         rvld_ff  <= rvld_in;
      end
   end

   always_ff @(posedge clock) begin
      rdat_ff <= rdat_in;
   end

   // header byte and data byte form one address part
   assign part = {dstat.ch1, 6'd0} | {6'd0, dstat.ch2};

   // capture control, address filter and result register
   always_comb begin
      capt_in  = capt_ff;
      cnt_in   = cnt_ff;
      busy_in  = busy_ff;
      lowp_in  = lowp_ff;
      lowv_in  = lowv_ff;
      highp_in = highp_ff;
      highv_in = highv_ff;
      for (int i = 0; i < AGREE_DEPTH; i++) hist_in[i] = hist_ff[i];
      hptr_in  = hptr_ff;
      acc_in   = acc_ff;
      rvld_in  = rvld_ff && !rsp_ready;
      rdat_in  = rdat_ff;
      addr     = '0;
      all_eq   = 1'b0;
      updated  = 1'b0;

      if (accept) begin
         case (req_data.action)
            ACT_START: begin
               cnt_in  = '0;
               capt_in = 1'b1;
            end
            ACT_SAMPLE: begin
               if (wr_en) cnt_in = cnt_ff + CW'(1);
            end
            ACT_DECODE: begin
               capt_in = 1'b0;
               if (dec_start) busy_in = 1'b1;
            end
            ACT_CLEAR: begin
               acc_in = '0;
            end
            default: begin
               acc_in = acc_ff;
            end
         endcase
         if (!dec_start) begin
            rvld_in                 = 1'b1;
            rdat_in.last_address    = acc_in[14:0];
            rdat_in.address_updated = 1'b0;
            rdat_in.channel_one     = 8'd0;
            rdat_in.channel_two     = 8'd0;
         end
      end

      // decode finished: latch parts and run the agreement filter
      if (dec_ack) begin
         busy_in = 1'b0;
         if (dstat.ch1 != 8'd0) begin
            if (dstat.ch1[LOW_BIT]) begin
               lowp_in = part;
               lowv_in = 1'b1;
            end
            if (dstat.ch1[HIGH_BIT]) begin
               highp_in = part;
               highv_in = 1'b1;
            end
            if (lowv_in && highv_in) begin
               if (highp_in < 14'(HIGH_OFFSET)) begin
                  addr = {2'd0, lowp_in};
               end else begin
                  addr = 16'({highp_in - 14'(HIGH_OFFSET), 8'd0}) + {2'd0, lowp_in};
               end
               hist_in[hptr_ff] = addr;
               hptr_in = hptr_ff + 2'd1;
               all_eq = 1'b1;
               for (int i = 0; i < AGREE_DEPTH; i++) begin
                  if (hist_in[i] != addr) all_eq = 1'b0;
               end
               if (all_eq && !addr[15]) begin
                  acc_in   = addr;
                  updated  = 1'b1;
                  lowv_in  = 1'b0;
                  highv_in = 1'b0;
               end
            end
         end
         rvld_in                 = 1'b1;
         rdat_in.last_address    = acc_in[14:0];
         rdat_in.address_updated = updated;
         rdat_in.channel_one     = dstat.ch1;
         rdat_in.channel_two     = dstat.ch2;
      end
   end

   assign rsp_valid = rvld_ff;
   assign rsp_data  = rdat_ff;

   // checks
   a_no_req_while_busy: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> !req_ready) else $error("request taken during decode");
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CW'(SAMPLE_DEPTH)) else $error("sample count past depth");
   a_done_in_busy: assert property (@(posedge clock) disable iff (reset)
      dstat.done |-> busy_ff) else $error("decoder done without decode");
   a_update_header: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.address_updated |-> rsp_data.channel_one != 8'd0)
      else $error("address update without header");

endmodule

`default_nettype wire
